// ===== design/cis_pkg.sv =====
`default_nettype none
package cis_pkg;

	// spdu tags
	localparam logic [7:0] TAG_DATA       = 8'h90;
	localparam logic [7:0] TAG_OPEN_REQ   = 8'h91;
	localparam logic [7:0] TAG_CREATE_RSP = 8'h94;
	localparam logic [7:0] TAG_CLOSE_REQ  = 8'h95;

	localparam logic [7:0] ST_OK      = 8'h00;
	localparam logic [7:0] ST_UNKNOWN = 8'hF0;
	localparam logic [7:0] ST_FULL    = 8'hF3;

	localparam logic [31:0] RID_RES_MGR = 32'h0001_0041;
	localparam logic [31:0] RID_APP_MGR = 32'h0002_0041;
	localparam logic [31:0] RID_CA_MGR  = 32'h0003_0041;
	localparam logic [31:0] RID_DATE    = 32'h0024_0041;
	localparam logic [31:0] RID_MMI     = 32'h0040_0041;

	localparam logic [2:0] RK_NONE    = 3'd0;
	localparam logic [2:0] RK_RES_MGR = 3'd1;
	localparam logic [2:0] RK_APP_MGR = 3'd2;
	localparam logic [2:0] RK_CA_MGR  = 3'd3;
	localparam logic [2:0] RK_DATE    = 3'd4;
	localparam logic [2:0] RK_MMI     = 3'd5;

	localparam logic [6:0] LEN_COUNT_MASK = 7'h7F;

	localparam logic [1:0] ACT_BYTE  = 2'd0;
	localparam logic [1:0] ACT_DROP  = 2'd1;
	localparam logic [1:0] ACT_SWEEP = 2'd2;

	// session entry phases
	localparam logic [1:0] PHS_FREE     = 2'd0;
	localparam logic [1:0] PHS_CREATING = 2'd1;
	localparam logic [1:0] PHS_STARTED  = 2'd2;
	localparam logic [1:0] PHS_DELETING = 2'd3;

	// parser phases
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_SLEN  = 4'd1;
	localparam logic [3:0] PH_SLENX = 4'd2;
	localparam logic [3:0] PH_BODY  = 4'd3;
	localparam logic [3:0] PH_ATAG  = 4'd4;
	localparam logic [3:0] PH_ALEN  = 4'd5;
	localparam logic [3:0] PH_ALENX = 4'd6;
	localparam logic [3:0] PH_ABODY = 4'd7;
	localparam logic [3:0] PH_SKIP  = 4'd8;

	localparam logic [3:0] EV_OPEN_RSP   = 4'd0;
	localparam logic [3:0] EV_STARTED    = 4'd1;
	localparam logic [3:0] EV_CLOSE_REQ  = 4'd2;
	localparam logic [3:0] EV_APDU_HDR   = 4'd3;
	localparam logic [3:0] EV_APDU_BYTE  = 4'd4;
	localparam logic [3:0] EV_CLOSE_RSP  = 4'd5;
	localparam logic [3:0] EV_ILLEGAL    = 4'd6;
	localparam logic [3:0] EV_CLOSED     = 4'd7;
	localparam logic [3:0] EV_UNKNOWN    = 4'd8;
	localparam logic [3:0] EV_LEN_MISM   = 4'd9;
	localparam logic [3:0] EV_BAD_LEN    = 4'd10;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  slot;
		logic [7:0]  data_byte;
		logic        first_byte;
		logic [11:0] packet_length;
	} in_t;

	typedef struct packed {
		logic [3:0]  event_kind;
		logic [3:0]  session_number;
		logic [7:0]  response_status;
		logic [31:0] resource_id;
		logic [2:0]  resource_kind;
		logic [23:0] apdu_tag;
		logic [15:0] apdu_length;
		logic [7:0]  payload_byte;
		logic        apdu_end;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [1:0] slot;
		logic [1:0] phase;
		logic [2:0] kind;
		logic [7:0] status;
	} entry_t;

	typedef struct packed {
		logic       mwe;
		entry_t     mdata;
		logic       vwe;
		logic       vval;
	} tbl_wr_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [11:0] bytes_left;
		logic [7:0]  tag;
		logic [15:0] body_left;
		logic [31:0] body_shift;
		logic [23:0] atag;
		logic [15:0] apdu_left;
		logic [6:0]  lenx;
		logic [1:0]  atag_cnt;
		logic [2:0]  seen;
	} psr_t;

	function automatic logic [2:0] res_kind(input logic [31:0] rid);
		logic [2:0] k;
		case (rid)
			RID_RES_MGR: k = RK_RES_MGR;
			RID_APP_MGR: k = RK_APP_MGR;
			RID_CA_MGR:  k = RK_CA_MGR;
			RID_DATE:    k = RK_DATE;
			RID_MMI:     k = RK_MMI;
			default:     k = RK_NONE;
		endcase
		return k;
	endfunction

	function automatic res_t mk_ev(input logic [3:0] k, input logic [3:0] s,
			input logic [7:0] st, input logic [31:0] rid, input logic [2:0] rk,
			input logic [23:0] at, input logic [15:0] al, input logic [7:0] pb,
			input logic e);
		res_t r;
		r.event_kind      = k;
		r.session_number  = s;
		r.response_status = st;
		r.resource_id     = rid;
		r.resource_kind   = rk;
		r.apdu_tag        = at;
		r.apdu_length     = al;
		r.payload_byte    = pb;
		r.apdu_end        = e;
		r.last            = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/ci_session_spdu_receiver.sv =====
`default_nettype none
// Session-layer receiver for a common-interface module link. Each packet byte
// is one beat on rx; results leave on ev, up to two per beat, the last one
// flagged. An SPDU that names an existing session waits for the session table
// read. A slot drop or a close sweep walks the session table, one entry per
// cycle (the close sweep stops at the first deleting entry). No clearing pass
// is needed after reset. The config write (cfg_data, tail workaround enable,
// reset 1) is taken at any time but should be made while idle.
module ci_session_spdu_receiver #(
	parameter int SESSION_TABLE = 16,
	parameter int SLOT_COUNT = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic          cfg_data,
	input  wire logic          rx_valid,
	output logic               rx_ready,
	input  wire cis_pkg::in_t  rx_data,
	output logic               ev_valid,
	input  wire logic          ev_ready,
	output cis_pkg::res_t      ev_data
);
	import cis_pkg::*;

	localparam int SW = $clog2(SESSION_TABLE);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SD    = 3'd2;
	localparam logic [2:0] S_DROP  = 3'd3;
	localparam logic [2:0] S_CLOSE = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]    state_q, state_d;
	in_t           in_q;
	logic          tail_q;
	res_t          res_q [2];
	logic [1:0]    cnt_q;
	logic          idx_q;
	logic [SW-1:0] sw_q, chk_q;
	logic          chkv_q;

	logic                     slot_ok, step, finish, defer;
	res_t                     p_ev0, p_ev1, cls_ev;
	logic [1:0]               p_cnt;
	tbl_wr_t                  p_wr, t_wr;
	logic [SW-1:0]            p_waddr, p_raddr, t_waddr, t_raddr;
	entry_t                   rent;
	logic [SESSION_TABLE-1:0] valid;
	logic [SW-1:0]            free_idx;
	logic                     full;
	logic                     sw_done, hit_drop, hit_close;
	logic [31:0]              chk_w;

	assign cfg_ready = 1'b1;
	assign rx_ready  = (state_q == S_IDLE);
	assign slot_ok   = int'(in_q.slot) < SLOT_COUNT;
	assign step      = (state_q == S_EXEC) && in_q.action == ACT_BYTE && slot_ok;
	assign finish    = (state_q == S_SD);

	assign sw_done   = chkv_q && chk_q == SW'(SESSION_TABLE - 1);
	assign hit_drop  = (state_q == S_DROP) && chkv_q && valid[chk_q] &&
		rent.slot == in_q.slot;
	assign hit_close = (state_q == S_CLOSE) && chkv_q && valid[chk_q] &&
		rent.phase == PHS_DELETING;
	assign chk_w     = 32'(chk_q);
	assign cls_ev    = mk_ev(EV_CLOSE_RSP, chk_w[3:0], '0, '0, rent.kind, '0, '0, '0,
		1'b0);

	cis_parser #(.SESSION_TABLE(SESSION_TABLE), .SW(SW)) u_parser (
		.clk(clk), .arst_n(arst_n), .step(step), .finish(finish), .it(in_q),
		.tail_en(tail_q), .valid(valid), .free_idx(free_idx), .full(full),
		.rent(rent), .ev0(p_ev0), .ev1(p_ev1), .cnt(p_cnt), .defer(defer),
		.wr(p_wr), .waddr(p_waddr), .raddr(p_raddr)
	);

	always_comb begin
		t_wr = p_wr;
		t_waddr = p_waddr;
		if (hit_drop || hit_close) begin
			t_wr = '0;
			t_wr.vwe = 1'b1;
			t_wr.vval = 1'b0;
			t_waddr = chk_q;
		end
		t_raddr = (state_q == S_DROP || state_q == S_CLOSE) ? sw_q : p_raddr;
	end

	cis_table #(.SESSION_TABLE(SESSION_TABLE), .SW(SW)) u_table (
		.clk(clk), .arst_n(arst_n), .raddr(t_raddr), .rdata(rent), .wr(t_wr),
		.waddr(t_waddr), .valid(valid), .free_idx(free_idx), .full(full)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (rx_valid) state_d = S_EXEC;
			S_EXEC: begin
				if (in_q.action == ACT_BYTE && slot_ok) begin
					if (defer) state_d = S_SD;
					else if (p_cnt != '0) state_d = S_OUT;
					else state_d = S_IDLE;
				end else if (in_q.action == ACT_DROP && slot_ok) begin
					state_d = S_DROP;
				end else if (in_q.action == ACT_SWEEP) begin
					state_d = S_CLOSE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SD: state_d = (p_cnt != '0) ? S_OUT : S_IDLE;
			S_DROP: if (sw_done) state_d = S_IDLE;
			S_CLOSE: begin
				if (hit_close) state_d = S_OUT;
				else if (sw_done) state_d = S_IDLE;
			end
			S_OUT: if (ev_ready && ev_data.last) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tail_q  <= 1'b1;
			cnt_q   <= '0;
			idx_q   <= 1'b0;
			sw_q    <= '0;
			chk_q   <= '0;
			chkv_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid)
				tail_q <= cfg_data;
			if (state_q == S_EXEC || state_q == S_SD) begin
				cnt_q <= p_cnt;
				idx_q <= 1'b0;
			end
			if (hit_close) begin
				cnt_q <= 2'd1;
				idx_q <= 1'b0;
			end
			if (state_q == S_OUT && ev_ready)
				idx_q <= 1'b1;
			// table walk: read one entry per cycle, check it the next
			if (state_q == S_EXEC) begin
				sw_q   <= SW'(1);
				chkv_q <= 1'b0;
			end else if (state_q == S_DROP || state_q == S_CLOSE) begin
				sw_q   <= sw_q + 1'b1;
				chk_q  <= sw_q;
				chkv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready)
			in_q <= rx_data;
		if (state_q == S_EXEC || state_q == S_SD) begin
			res_q[0] <= p_ev0;
			res_q[1] <= p_ev1;
		end
		if (hit_close)
			res_q[0] <= cls_ev;
	end

	always_comb begin
		ev_data = res_q[idx_q];
		ev_data.last = ({1'b0, idx_q} + 2'd1) == cnt_q;
	end
	assign ev_valid = (state_q == S_OUT);

endmodule
`default_nettype wire

// ===== design/cis_table.sv =====
`default_nettype none
module cis_table #(
	parameter int SESSION_TABLE = 16,
	parameter int SW = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [SW-1:0]    raddr,
	output cis_pkg::entry_t       rdata,
	input  wire cis_pkg::tbl_wr_t wr,
	input  wire logic [SW-1:0]    waddr,
	output logic [SESSION_TABLE-1:0] valid,
	output logic [SW-1:0]         free_idx,
	output logic                  full
);
	import cis_pkg::*;

	entry_t mem [SESSION_TABLE];
	logic [SESSION_TABLE-1:0] valid_q;
	logic [SESSION_TABLE-1:0] free_v;
	logic [SESSION_TABLE-1:0] low_v;

	always_ff @(posedge clk) begin
		if (wr.mwe)
			mem[waddr] <= wr.mdata;
		rdata <= mem[raddr];
	end

	// entry 0 is never a session
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.vwe && waddr != '0) begin
			valid_q[waddr] <= wr.vval;
		end
	end

	assign valid = valid_q;

	// lowest free entry: isolate lowest set bit, then encode
	always_comb begin
		free_v = ~valid_q;
		free_v[0] = 1'b0;
		low_v = free_v & (~free_v + 1'b1);
		free_idx = '0;
		for (int i = 0; i < SESSION_TABLE; i++) begin
			if (low_v[i])
				free_idx = free_idx | SW'(i);
		end
		full = (free_v == '0);
	end

endmodule
`default_nettype wire

// ===== design/cis_parser.sv =====
`default_nettype none
module cis_parser #(
	parameter int SESSION_TABLE = 16,
	parameter int SW = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     step,
	input  wire logic                     finish,
	input  wire cis_pkg::in_t             it,
	input  wire logic                     tail_en,
	input  wire logic [SESSION_TABLE-1:0] valid,
	input  wire logic [SW-1:0]            free_idx,
	input  wire logic                     full,
	input  wire cis_pkg::entry_t          rent,
	output cis_pkg::res_t                 ev0,
	output cis_pkg::res_t                 ev1,
	output logic [1:0]                    cnt,
	output logic                          defer,
	output cis_pkg::tbl_wr_t              wr,
	output logic [SW-1:0]                 waddr,
	output logic [SW-1:0]                 raddr
);
	import cis_pkg::*;

	psr_t          p_q, n;
	logic [SW-1:0] cs_q, ncs;
	logic [1:0]    slot_q, nslot;
	logic [2:0]    kind_q, nkind;
	logic          end_q;
	logic [2:0]    kcur;
	res_t          evs [2];
	logic          do_sd, do_ar, is_end;
	logic [15:0]   alen, rem16, nb;
	logic [2:0]    rk;
	logic [7:0]    st;
	logic [7:0]    b;

	function automatic logic [3:0] sn4(input logic [SW-1:0] s);
		logic [31:0] w;
		w = 32'(s);
		return w[3:0];
	endfunction

	assign b = it.data_byte;
	assign kcur = (cs_q != '0 && valid[cs_q]) ? kind_q : RK_NONE;

	always_comb begin
		n = p_q; ncs = cs_q; nslot = slot_q; nkind = kind_q;
		evs[0] = '0; evs[1] = '0; cnt = '0; defer = 1'b0;
		wr = '0; waddr = '0; raddr = '0;
		do_sd = 1'b0; do_ar = 1'b0; is_end = 1'b0;
		alen = '0; rem16 = '0; nb = '0; rk = RK_NONE; st = ST_OK;
		if (finish) begin
			n.phase = PH_ATAG; n.atag_cnt = '0; n.atag = '0;
			nkind = rent.kind;
			case (p_q.tag)
				TAG_CREATE_RSP: begin
					wr.mwe = 1'b1; waddr = cs_q;
					wr.mdata = '{slot: rent.slot, phase: PHS_STARTED, kind: rent.kind,
						status: p_q.body_shift[31:24]};
					evs[0] = mk_ev(EV_STARTED, sn4(cs_q), p_q.body_shift[31:24], '0,
						rent.kind, '0, '0, '0, 1'b0);
					cnt = 2'd1;
				end
				TAG_CLOSE_REQ: begin
					wr.mwe = 1'b1; waddr = cs_q;
					wr.mdata = '{slot: rent.slot, phase: PHS_DELETING, kind: rent.kind,
						status: rent.status};
					evs[0] = mk_ev(EV_CLOSE_REQ, sn4(cs_q), '0, '0, rent.kind, '0, '0, '0,
						1'b0);
					cnt = 2'd1;
				end
				TAG_DATA: ;
				default: begin
					evs[0] = mk_ev(EV_UNKNOWN, sn4(cs_q), '0, '0, rent.kind, '0, '0, '0,
						1'b0);
					cnt = 2'd1;
					n.phase = PH_SKIP;
				end
			endcase
			if (end_q)
				n.phase = PH_IDLE;
		end else if (step) begin
			if (it.first_byte) begin
				n.tag = b;
				n.bytes_left = (it.packet_length != '0) ? it.packet_length - 12'd1 : '0;
				n.body_left = '0; n.body_shift = '0; n.seen = '0;
				nslot = it.slot; ncs = '0;
				n.atag = '0; n.apdu_left = '0; n.lenx = '0; n.atag_cnt = '0;
				n.phase = PH_SLEN;
				if (n.bytes_left == '0) begin
					evs[0] = mk_ev(EV_BAD_LEN, '0, '0, '0, '0, '0, '0, '0, 1'b0);
					cnt = 2'd1;
					n.phase = PH_IDLE;
				end
			end else if (p_q.phase != PH_IDLE) begin
				n.bytes_left = p_q.bytes_left - 12'd1;
				is_end = (n.bytes_left == '0);
				unique case (p_q.phase)
					PH_SLEN: begin
						if (b[7] && (b[6:0] & LEN_COUNT_MASK) != '0) begin
							n.lenx = b[6:0]; n.phase = PH_SLENX; n.body_left = '0;
						end else begin
							n.body_left = b[7] ? 16'd0 : {8'd0, b};
							if (n.body_left != '0) n.phase = PH_BODY;
							else do_sd = 1'b1;
						end
					end
					PH_ALEN: begin
						if (b[7] && (b[6:0] & LEN_COUNT_MASK) != '0) begin
							n.lenx = b[6:0]; n.phase = PH_ALENX; n.apdu_left = '0;
						end else begin
							n.apdu_left = b[7] ? 16'd0 : {8'd0, b};
							do_ar = 1'b1;
						end
					end
					PH_SLENX: begin
						n.body_left = {p_q.body_left[7:0], b};
						n.lenx = p_q.lenx - 7'd1;
						if (n.lenx == '0) begin
							if (n.body_left != '0) n.phase = PH_BODY;
							else do_sd = 1'b1;
						end
					end
					PH_ALENX: begin
						n.apdu_left = {p_q.apdu_left[7:0], b};
						n.lenx = p_q.lenx - 7'd1;
						if (n.lenx == '0) do_ar = 1'b1;
					end
					PH_BODY: begin
						if (p_q.seen == 3'd0) n.body_shift[31:24] = b;
						if (p_q.tag == TAG_OPEN_REQ) begin
							case (p_q.seen)
								3'd1: n.body_shift[23:16] = n.body_shift[23:16] | b;
								3'd2: n.body_shift[15:8] = n.body_shift[15:8] | b;
								3'd3: n.body_shift[7:0] = n.body_shift[7:0] | b;
								default: ;
							endcase
						end else begin
							n.body_shift[15:0] = {n.body_shift[7:0], b};
						end
						if (p_q.seen < 3'd4) n.seen = p_q.seen + 3'd1;
						n.body_left = p_q.body_left - 16'd1;
						if (n.body_left == '0) do_sd = 1'b1;
					end
					PH_ATAG: begin
						n.atag = {p_q.atag[15:0], b};
						n.atag_cnt = p_q.atag_cnt + 2'd1;
						if (n.atag_cnt == 2'd3) n.phase = PH_ALEN;
					end
					PH_ABODY: begin
						n.apdu_left = p_q.apdu_left - 16'd1;
						evs[0] = mk_ev(EV_APDU_BYTE, sn4(cs_q), '0, '0, kcur, '0, '0, b,
							n.apdu_left == '0);
						cnt = 2'd1;
						if (n.apdu_left == '0) begin
							n.phase = PH_ATAG; n.atag_cnt = '0; n.atag = '0;
						end
					end
					default: ;
				endcase

				if (do_ar) begin
					alen = n.apdu_left;
					rem16 = {4'd0, n.bytes_left};
					if (tail_en && rem16 > alen && (rem16 - alen) < 16'd3)
						alen = rem16;
					n.apdu_left = alen;
					evs[0] = mk_ev(EV_APDU_HDR, sn4(cs_q), '0, '0, kcur, n.atag, alen, '0,
						alen == '0);
					cnt = 2'd1;
					if (alen != '0) begin
						n.phase = PH_ABODY;
					end else begin
						n.phase = PH_ATAG; n.atag_cnt = '0; n.atag = '0;
					end
				end

				if (do_sd) begin
					if (p_q.tag == TAG_OPEN_REQ) begin
						if (full) begin
							st = ST_FULL;
						end else begin
							rk = res_kind(n.body_shift);
							st = (rk == RK_NONE) ? ST_UNKNOWN : ST_OK;
						end
						if (!full && rk != RK_NONE) begin
							wr.mwe = 1'b1; wr.vwe = 1'b1; wr.vval = 1'b1; waddr = free_idx;
							wr.mdata = '{slot: slot_q, phase: PHS_STARTED, kind: rk,
								status: ST_OK};
							evs[0] = mk_ev(EV_OPEN_RSP, sn4(free_idx), st, n.body_shift, rk,
								'0, '0, '0, 1'b0);
							evs[1] = mk_ev(EV_STARTED, sn4(free_idx), '0, '0, rk, '0, '0, '0,
								1'b0);
							cnt = 2'd2;
							ncs = free_idx; nkind = rk;
							n.phase = PH_ATAG; n.atag_cnt = '0; n.atag = '0;
						end else begin
							evs[0] = mk_ev(EV_OPEN_RSP, '0, st, n.body_shift, rk, '0, '0, '0,
								1'b0);
							cnt = 2'd1;
							if (!is_end) begin
								evs[1] = mk_ev(EV_LEN_MISM, '0, '0, '0, '0, '0, '0, '0, 1'b0);
								cnt = 2'd2;
							end
							n.phase = PH_SKIP;
						end
					end else begin
						nb = n.body_shift[15:0];
						if (nb == '0 || nb >= 16'(SESSION_TABLE)) begin
							n.phase = PH_SKIP;
							evs[0] = mk_ev(EV_ILLEGAL, nb[3:0], '0, '0, '0, '0, '0, '0, 1'b0);
							cnt = 2'd1;
						end else if (!valid[SW'(nb)]) begin
							n.phase = PH_SKIP;
							evs[0] = mk_ev(EV_CLOSED, nb[3:0], '0, '0, '0, '0, '0, '0, 1'b0);
							cnt = 2'd1;
						end else begin
							// entry needed: finish after the table read
							defer = 1'b1;
							raddr = SW'(nb);
							ncs = SW'(nb);
						end
					end
				end

				if (is_end && !defer) begin
					if (n.phase == PH_SLEN || n.phase == PH_SLENX || n.phase == PH_BODY) begin
						evs[cnt[0]] = mk_ev(EV_BAD_LEN, '0, '0, '0, '0, '0, '0, '0, 1'b0);
						cnt = cnt + 2'd1;
					end else if ((n.phase == PH_ATAG && n.atag_cnt != '0) ||
							n.phase == PH_ALEN || n.phase == PH_ALENX ||
							n.phase == PH_ABODY) begin
						evs[cnt[0]] = mk_ev(EV_LEN_MISM, sn4(cs_q), '0, '0, kcur, '0, '0,
							'0, 1'b0);
						cnt = cnt + 2'd1;
					end
					n.phase = PH_IDLE;
				end
			end
		end
		ev0 = evs[0];
		ev1 = evs[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= '0;
			cs_q   <= '0;
			slot_q <= '0;
			kind_q <= '0;
			end_q  <= 1'b0;
		end else if (step || finish) begin
			p_q    <= n;
			cs_q   <= ncs;
			slot_q <= nslot;
			kind_q <= nkind;
			if (defer)
				end_q <= is_end;
		end
	end

endmodule
`default_nettype wire

// ===== tb/ci_session_spdu_receiver_test.sv =====
`default_nettype none
module ci_session_spdu_receiver_test;
	import cis_pkg::*;

	localparam int TABLE_SIZE = 16;
	localparam int SLOTS = 4;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	logic rx_valid;
	logic rx_ready;
	in_t rx_data;
	logic ev_valid;
	logic ev_ready;
	res_t ev_data;

	ci_session_spdu_receiver #(.SESSION_TABLE(TABLE_SIZE), .SLOT_COUNT(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_data(rx_data),
		.ev_valid(ev_valid),
		.ev_ready(ev_ready),
		.ev_data(ev_data)
	);

	// predictor state
	logic tail_fix;
	logic tbl_valid [TABLE_SIZE];
	logic [1:0] tbl_slot [TABLE_SIZE];
	logic [1:0] tbl_phase [TABLE_SIZE];
	logic [2:0] tbl_kind [TABLE_SIZE];
	logic [7:0] tbl_status [TABLE_SIZE];
	logic [3:0] ps_phase;
	logic [11:0] ps_left;
	logic [7:0] ps_tag;
	logic [15:0] ps_body_left;
	logic [31:0] ps_shift;
	logic [3:0] ps_sess;
	logic [23:0] ps_atag;
	logic [15:0] ps_apdu_left;
	logic [6:0] ps_lenx;
	int ps_atag_cnt;
	int ps_seen;
	logic [1:0] ps_slot;

	in_t pending_bytes[$];
	res_t expected_events[$];
	int errors;
	int events_seen;
	int bytes_sent;
	int burst_left;
	int gap_left;
	int stall_phase;
	bit stall_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("FAILURE");
		$finish;
	end

	task automatic report(input string what, input res_t got, input res_t want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	function automatic void push_ev(input logic [3:0] k, input logic [3:0] s,
			input logic [7:0] st, input logic [31:0] rid, input logic [2:0] rk,
			input logic [23:0] at, input logic [15:0] al, input logic [7:0] pb,
			input logic e);
		res_t r;
		r.event_kind = k;
		r.session_number = s;
		r.response_status = st;
		r.resource_id = rid;
		r.resource_kind = rk;
		r.apdu_tag = at;
		r.apdu_length = al;
		r.payload_byte = pb;
		r.apdu_end = e;
		r.last = 1'b0;
		expected_events.push_back(r);
	endfunction

	function automatic logic [2:0] kind_for_rid(input logic [31:0] rid);
		logic [2:0] k;
		k = RK_NONE;
		if (rid == RID_RES_MGR) k = RK_RES_MGR;
		else if (rid == RID_APP_MGR) k = RK_APP_MGR;
		else if (rid == RID_CA_MGR) k = RK_CA_MGR;
		else if (rid == RID_DATE) k = RK_DATE;
		else if (rid == RID_MMI) k = RK_MMI;
		return k;
	endfunction

	function automatic logic [2:0] session_kind(input logic [3:0] s);
		if (s == 0 || !tbl_valid[s - 1]) return RK_NONE;
		return tbl_kind[s - 1];
	endfunction

	function automatic void free_entry(input int i);
		tbl_valid[i] = 1'b0;
		tbl_slot[i] = '0;
		tbl_phase[i] = PHS_FREE;
		tbl_kind[i] = RK_NONE;
		tbl_status[i] = '0;
	endfunction

	function automatic void start_apdus(input logic [3:0] s);
		ps_sess = s;
		ps_phase = PH_ATAG;
		ps_atag_cnt = 0;
		ps_atag = '0;
	endfunction

	function automatic void finish_spdu(input bit at_end);
		int i;
		logic [2:0] rk;
		logic [7:0] st;
		logic [3:0] s;
		logic [15:0] nb;
		if (ps_tag == TAG_OPEN_REQ) begin
			rk = RK_NONE;
			s = 0;
			for (i = 0; i < TABLE_SIZE - 1; i++)
				if (!tbl_valid[i]) break;
			if (i >= TABLE_SIZE - 1) begin
				st = ST_FULL;
			end else begin
				rk = kind_for_rid(ps_shift);
				if (rk == RK_NONE) begin
					st = ST_UNKNOWN;
				end else begin
					tbl_valid[i] = 1'b1;
					tbl_slot[i] = ps_slot;
					tbl_phase[i] = PHS_STARTED;
					tbl_kind[i] = rk;
					tbl_status[i] = ST_OK;
					st = ST_OK;
					s = i + 1;
				end
			end
			push_ev(EV_OPEN_RSP, s, st, ps_shift, rk, 0, 0, 0, 0);
			if (s != 0) begin
				push_ev(EV_STARTED, s, 0, 0, rk, 0, 0, 0, 0);
				start_apdus(s);
			end else begin
				if (!at_end) push_ev(EV_LEN_MISM, 0, 0, 0, 0, 0, 0, 0, 0);
				ps_phase = PH_SKIP;
			end
			return;
		end
		nb = ps_shift[15:0];
		if (nb == 0 || nb >= TABLE_SIZE) begin
			ps_phase = PH_SKIP;
			push_ev(EV_ILLEGAL, nb[3:0], 0, 0, 0, 0, 0, 0, 0);
			return;
		end
		if (!tbl_valid[nb - 1]) begin
			ps_phase = PH_SKIP;
			push_ev(EV_CLOSED, nb[3:0], 0, 0, 0, 0, 0, 0, 0);
			return;
		end
		if (ps_tag == TAG_CREATE_RSP) begin
			tbl_status[nb - 1] = ps_shift[31:24];
			tbl_phase[nb - 1] = PHS_STARTED;
			push_ev(EV_STARTED, nb[3:0], ps_shift[31:24], 0, tbl_kind[nb - 1], 0, 0, 0, 0);
		end else if (ps_tag == TAG_CLOSE_REQ) begin
			tbl_phase[nb - 1] = PHS_DELETING;
			push_ev(EV_CLOSE_REQ, nb[3:0], 0, 0, tbl_kind[nb - 1], 0, 0, 0, 0);
		end else if (ps_tag != TAG_DATA) begin
			ps_phase = PH_SKIP;
			push_ev(EV_UNKNOWN, nb[3:0], 0, 0, tbl_kind[nb - 1], 0, 0, 0, 0);
			return;
		end
		start_apdus(nb[3:0]);
	endfunction

	function automatic void apdu_header_done();
		logic [15:0] alen;
		alen = ps_apdu_left;
		if (tail_fix && {4'd0, ps_left} > alen && {4'd0, ps_left} - alen < 3)
			alen = {4'd0, ps_left};
		ps_apdu_left = alen;
		push_ev(EV_APDU_HDR, ps_sess, 0, 0, session_kind(ps_sess), ps_atag, alen, 0,
			alen == 0);
		if (alen != 0) ps_phase = PH_ABODY;
		else start_apdus(ps_sess);
	endfunction

	function automatic void predict_item(input in_t it);
		int i;
		int n0;
		bit at_end;
		bit is_slen;
		logic [7:0] b;
		n0 = expected_events.size();
		b = it.data_byte;
		if (it.action == ACT_DROP) begin
			for (i = 0; i < TABLE_SIZE - 1; i++)
				if (tbl_valid[i] && tbl_slot[i] == it.slot) free_entry(i);
			return;
		end
		if (it.action == ACT_SWEEP) begin
			for (i = 0; i < TABLE_SIZE - 1; i++)
				if (tbl_valid[i] && tbl_phase[i] == PHS_DELETING) begin
					push_ev(EV_CLOSE_RSP, i + 1, 0, 0, tbl_kind[i], 0, 0, 0, 0);
					free_entry(i);
					break;
				end
		end else if (it.action == ACT_BYTE) begin
			if (it.first_byte) begin
				ps_tag = b;
				ps_left = it.packet_length == 0 ? 12'd0 : it.packet_length - 1;
				ps_body_left = 0;
				ps_shift = 0;
				ps_seen = 0;
				ps_slot = it.slot;
				ps_sess = 0;
				ps_atag = 0;
				ps_apdu_left = 0;
				ps_lenx = 0;
				ps_atag_cnt = 0;
				ps_phase = PH_SLEN;
				if (ps_left == 0) begin
					push_ev(EV_BAD_LEN, 0, 0, 0, 0, 0, 0, 0, 0);
					ps_phase = PH_IDLE;
				end
			end else if (ps_phase != PH_IDLE) begin
				ps_left = ps_left - 1;
				at_end = ps_left == 0;
				case (ps_phase)
					PH_SLEN, PH_ALEN: begin
						is_slen = ps_phase == PH_SLEN;
						if (b[7] && b[6:0] != 0) begin
							ps_lenx = b[6:0] & LEN_COUNT_MASK;
							ps_phase = is_slen ? PH_SLENX : PH_ALENX;
							if (is_slen) ps_body_left = 0;
							else ps_apdu_left = 0;
						end else if (is_slen) begin
							ps_body_left = b[7] ? 16'd0 : {8'd0, b};
							if (ps_body_left != 0) ps_phase = PH_BODY;
							else finish_spdu(at_end);
						end else begin
							ps_apdu_left = b[7] ? 16'd0 : {8'd0, b};
							apdu_header_done();
						end
					end
					PH_SLENX: begin
						ps_body_left = {ps_body_left[7:0], b};
						ps_lenx = ps_lenx - 1;
						if (ps_lenx == 0) begin
							if (ps_body_left != 0) ps_phase = PH_BODY;
							else finish_spdu(at_end);
						end
					end
					PH_ALENX: begin
						ps_apdu_left = {ps_apdu_left[7:0], b};
						ps_lenx = ps_lenx - 1;
						if (ps_lenx == 0) apdu_header_done();
					end
					PH_BODY: begin
						if (ps_seen == 0) ps_shift[31:24] = b;
						if (ps_tag == TAG_OPEN_REQ) begin
							if (ps_seen >= 1 && ps_seen < 4)
								ps_shift = ps_shift | ({24'd0, b} << (24 - 8 * ps_seen));
						end else begin
							ps_shift[15:0] = {ps_shift[7:0], b};
						end
						if (ps_seen < 4) ps_seen++;
						ps_body_left = ps_body_left - 1;
						if (ps_body_left == 0) finish_spdu(at_end);
					end
					PH_ATAG: begin
						ps_atag = {ps_atag[15:0], b};
						ps_atag_cnt++;
						if (ps_atag_cnt == 3) ps_phase = PH_ALEN;
					end
					PH_ABODY: begin
						ps_apdu_left = ps_apdu_left - 1;
						push_ev(EV_APDU_BYTE, ps_sess, 0, 0, session_kind(ps_sess), 0, 0, b,
							ps_apdu_left == 0);
						if (ps_apdu_left == 0) start_apdus(ps_sess);
					end
					default: ;
				endcase
				if (at_end) begin
					if (ps_phase == PH_SLEN || ps_phase == PH_SLENX || ps_phase == PH_BODY)
						push_ev(EV_BAD_LEN, 0, 0, 0, 0, 0, 0, 0, 0);
					else if ((ps_phase == PH_ATAG && ps_atag_cnt != 0) || ps_phase == PH_ALEN
							|| ps_phase == PH_ALENX || ps_phase == PH_ABODY)
						push_ev(EV_LEN_MISM, ps_sess, 0, 0, session_kind(ps_sess), 0, 0, 0, 0);
					ps_phase = PH_IDLE;
				end
			end
		end
		if (expected_events.size() > n0)
			expected_events[expected_events.size() - 1].last = 1'b1;
	endfunction

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (rx_valid && rx_ready) begin
				predict_item(rx_data);
				bytes_sent++;
			end
			if (!rx_valid || rx_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					rx_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					rx_data <= pending_bytes.pop_front();
					rx_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			if (ev_valid && ev_ready) begin
				events_seen++;
				if (expected_events.size() == 0) begin
					report("unexpected beat", ev_data, '0);
				end else begin
					res_t want;
					want = expected_events.pop_front();
					if (ev_data.event_kind != want.event_kind) report("event_kind", ev_data, want);
					else if (ev_data.session_number != want.session_number)
						report("session_number", ev_data, want);
					else if (ev_data.response_status != want.response_status)
						report("response_status", ev_data, want);
					else if (ev_data.resource_id != want.resource_id)
						report("resource_id", ev_data, want);
					else if (ev_data.resource_kind != want.resource_kind)
						report("resource_kind", ev_data, want);
					else if (ev_data.apdu_tag != want.apdu_tag) report("apdu_tag", ev_data, want);
					else if (ev_data.apdu_length != want.apdu_length)
						report("apdu_length", ev_data, want);
					else if (ev_data.payload_byte != want.payload_byte)
						report("payload_byte", ev_data, want);
					else if (ev_data.apdu_end != want.apdu_end) report("apdu_end", ev_data, want);
					else if (ev_data.last != want.last) report("last", ev_data, want);
				end
			end
			stall_phase <= stall_phase + 1;
			if (stall_mode) ev_ready <= 1'b1;
			else ev_ready <= (stall_phase % 7 < 4) || ($urandom_range(0, 3) == 0);
		end
	end

	task automatic wait_idle();
		while (pending_bytes.size() > 0 || rx_valid || expected_events.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_tail_fix(input logic v);
		wait_idle();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tail_fix = v;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void put_byte(input logic [1:0] sl, input logic [7:0] b, input bit f,
			input logic [11:0] plen);
		in_t it;
		it.action = ACT_BYTE;
		it.slot = sl;
		it.data_byte = b;
		it.first_byte = f;
		it.packet_length = plen;
		pending_bytes.push_back(it);
	endfunction

	function automatic void put_action(input logic [1:0] act, input logic [1:0] sl);
		in_t it;
		it = in_t'($urandom);
		it.action = act;
		it.slot = sl;
		pending_bytes.push_back(it);
	endfunction

	// send one packet; bytes list starts with the spdu tag
	function automatic void put_packet(input logic [1:0] sl, input logic [7:0] pkt[$],
			input int trim);
		int k;
		int n;
		n = pkt.size() - trim;
		if (n < 1) n = 1;
		for (k = 0; k < n; k++)
			put_byte(sl, pkt[k], k == 0, k == 0 ? n[11:0] : 12'($urandom));
	endfunction

	function automatic logic [31:0] pick_rid();
		case ($urandom_range(0, 5))
			0: return RID_RES_MGR;
			1: return RID_APP_MGR;
			2: return RID_CA_MGR;
			3: return RID_DATE;
			4: return RID_MMI;
			default: return $urandom;
		endcase
	endfunction

	// builds an spdu with random apdus; tail bytes and long length forms mixed in
	function automatic void random_packet();
		logic [7:0] pkt[$];
		logic [31:0] rid;
		logic [7:0] tag;
		int na;
		int len;
		int k;
		int sess;
		case ($urandom_range(0, 9))
			0, 1, 2: tag = TAG_OPEN_REQ;
			3, 4, 5: tag = TAG_DATA;
			6: tag = TAG_CREATE_RSP;
			7: tag = TAG_CLOSE_REQ;
			default: tag = $urandom;
		endcase
		sess = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : $urandom_range(1, 5);
		pkt.push_back(tag);
		if (tag == TAG_OPEN_REQ) begin
			rid = pick_rid();
			pkt.push_back(8'd4);
			for (k = 3; k >= 0; k--) pkt.push_back(rid[8 * k +: 8]);
		end else if (tag == TAG_CREATE_RSP) begin
			pkt.push_back(8'd3);
			pkt.push_back($urandom);
			pkt.push_back(sess[15:8]);
			pkt.push_back(sess[7:0]);
		end else begin
			if ($urandom_range(0, 4) == 0) begin
				pkt.push_back(8'h82);
				pkt.push_back(8'h00);
			end
			pkt.push_back(8'd2);
			pkt.push_back(sess[15:8]);
			pkt.push_back(sess[7:0]);
		end
		na = $urandom_range(0, 2);
		for (k = 0; k < na; k++) begin
			len = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 10);
			pkt.push_back(8'h9F);
			pkt.push_back($urandom);
			pkt.push_back($urandom);
			if ($urandom_range(0, 3) == 0) begin
				pkt.push_back(8'h82);
				pkt.push_back(8'h00);
				pkt.push_back(len[7:0]);
			end else begin
				pkt.push_back(len[7:0]);
			end
			repeat (len) pkt.push_back($urandom);
		end
		if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) pkt.push_back($urandom);
		put_packet($urandom_range(0, 3), pkt, $urandom_range(0, 6) == 0 ? $urandom_range(1, 4) : 0);
	endfunction

	initial begin
		logic [7:0] pkt[$];
		int phase_no;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		errors = 0;
		events_seen = 0;
		bytes_sent = 0;
		stall_mode = 1'b0;
		tail_fix = 1'b1;
		for (int i = 0; i < TABLE_SIZE; i++) free_entry(i);
		ps_phase = PH_IDLE;
		ps_left = 0;
		ps_tag = 0;
		ps_body_left = 0;
		ps_shift = 0;
		ps_sess = 0;
		ps_atag = 0;
		ps_apdu_left = 0;
		ps_lenx = 0;
		ps_atag_cnt = 0;
		ps_seen = 0;
		ps_slot = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: open, data with apdus, close, sweep, drop, tail fix writes, error cases
		pkt = {TAG_OPEN_REQ, 8'd4, 8'h00, 8'h01, 8'h00, 8'h41, 8'h9F, 8'h80, 8'h10, 8'd2,
			8'hFF, 8'h00};
		put_packet(2'd0, pkt, 0);
		pkt = {TAG_DATA, 8'h82, 8'h00, 8'd2, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h81, 8'd1,
			8'h7E, 8'h9F, 8'h00, 8'h00, 8'd0, 8'h55};
		put_packet(2'd0, pkt, 0);
		put_byte(2'd1, 8'h33, 1'b0, 12'hFFF);
		put_byte(2'd3, TAG_DATA, 1'b1, 12'd0);
		put_byte(2'd3, TAG_DATA, 1'b1, 12'd1);
		pkt = {TAG_CREATE_RSP, 8'd3, 8'hA5, 8'h00, 8'h01};
		put_packet(2'd1, pkt, 0);
		pkt = {TAG_DATA, 8'd2, 8'h00, 8'h0F};
		put_packet(2'd1, pkt, 0);
		pkt = {TAG_DATA, 8'd2, 8'h00, 8'h00};
		put_packet(2'd1, pkt, 0);
		pkt = {8'h77, 8'd2, 8'h00, 8'h01, 8'h00};
		put_packet(2'd1, pkt, 0);
		pkt = {TAG_OPEN_REQ, 8'd4, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h00};
		put_packet(2'd2, pkt, 0);
		pkt = {TAG_OPEN_REQ, 8'd1, 8'h00};
		put_packet(2'd2, pkt, 0);
		pkt = {TAG_DATA, 8'd2, 8'h00};
		put_packet(2'd2, pkt, 0);
		pkt = {TAG_CLOSE_REQ, 8'd2, 8'h00, 8'h01, 8'h9F, 8'h80};
		put_packet(2'd0, pkt, 0);
		put_action(ACT_SWEEP, 2'd0);
		put_action(ACT_SWEEP, 2'd3);
		put_action(2'd3, 2'd2);
		put_action(ACT_DROP, 2'd0);
		write_tail_fix(1'b0);
		pkt = {TAG_OPEN_REQ, 8'd4, 8'h00, 8'h40, 8'h00, 8'h41, 8'h9F, 8'h88, 8'h01, 8'd1,
			8'hAA, 8'hBB};
		put_packet(2'd1, pkt, 0);
		put_action(ACT_DROP, 2'd1);
		write_tail_fix(1'b1);

		// random phases with register changes between them
		for (phase_no = 0; phase_no < 6; phase_no++) begin
			stall_mode = phase_no == 3;
			while (pending_bytes.size() < 205) begin
				case ($urandom_range(0, 19))
					0: put_action(ACT_DROP, $urandom_range(0, 3));
					1, 2: put_action(ACT_SWEEP, $urandom_range(0, 3));
					3: put_byte($urandom, $urandom, $urandom_range(0, 1), $urandom);
					4: put_action(2'd3, $urandom);
					default: random_packet();
				endcase
			end
			write_tail_fix(phase_no[0]);
		end
		wait_idle();
		$display("sent %0d input beats, checked %0d result beats, %0d mismatches",
			bytes_sent, events_seen, errors);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire
